// ===== rtl/fdesc_pkg.sv =====
// ----------------------------------------------------------------------------
// fdesc_pkg
// Shared types and constants for the frame descrambler.
// ----------------------------------------------------------------------------
package fdesc_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned HeaderLen  = 4;
  localparam int unsigned GroupLen   = 4;
  localparam int unsigned LenW       = 16;
  localparam int unsigned StepW      = 3;

  // Result kind codes carried on m_tuser
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_CKSUM  = 2'd2
  } kind_t;

  // Work item handed from the front end to the back end
  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,   // one header byte, then optional checksum
    OP_GROUP  = 2'd1,   // four reordered data bytes, then optional checksum
    OP_CKSUM  = 2'd2    // checksum only
  } op_t;

  typedef struct packed {
    op_t                           op;
    logic [GroupLen-1:0][ByteW-1:0] bytes;   // in emission order, byte 0 first
    logic [ByteW-1:0]               cksum;
    logic                           with_cksum;
  } queue_entry_t;

  // Exchange bit 0 and bit 7
  function automatic logic [ByteW-1:0] swap_end_bits(input logic [ByteW-1:0] b);
    swap_end_bits = {b[0], b[6:1], b[7]};
  endfunction

endpackage

// ===== rtl/fdesc_front.sv =====
// ----------------------------------------------------------------------------
// fdesc_front
// Accepts frame bytes, tracks header/data position, builds work items.
// ----------------------------------------------------------------------------
module fdesc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [fdesc_pkg::ByteW-1:0]   s_tdata,   // [7:0] rx_byte
  input  logic                          s_tlast,   // frame_end
  input  logic                          q_full,
  output logic                          push,
  output fdesc_pkg::queue_entry_t       push_entry
);
  import fdesc_pkg::*;

  logic [2:0]       header_count, header_count_next;
  logic [LenW-1:0]  data_length, data_length_next;
  logic [LenW-1:0]  data_count, data_count_next;
  logic [ByteW-1:0] group_buffer [3];
  logic [ByteW-1:0] running_sum, running_sum_next;
  logic             checksum_done, checksum_done_next;

  logic             accept;
  logic             emit;
  logic [ByteW-1:0] x;
  logic [1:0]       pos;
  logic [ByteW-1:0] group_sum;
  logic             cks;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign x        = swap_end_bits(s_tdata);
  assign pos      = data_count[1:0];
  assign group_sum = group_buffer[0] + group_buffer[1] + group_buffer[2] + x;
  assign push     = accept && emit;

  always_comb begin
    header_count_next  = header_count;
    data_length_next   = data_length;
    data_count_next    = data_count;
    running_sum_next   = running_sum;
    checksum_done_next = checksum_done;
    emit               = 1'b0;
    cks                = 1'b0;
    push_entry.op         = OP_CKSUM;
    push_entry.bytes      = {group_buffer[2], group_buffer[0], x, group_buffer[1]};
    push_entry.cksum      = running_sum;
    push_entry.with_cksum = 1'b0;

    if (!checksum_done) begin
      if (header_count < 3'(HeaderLen)) begin
        emit = 1'b1;
        push_entry.op    = OP_HEADER;
        push_entry.bytes = {{(3*ByteW){1'b0}}, s_tdata};
        if (header_count == 3'd2) begin
          data_length_next = {{(LenW-ByteW){1'b0}}, s_tdata};
        end else if (header_count == 3'd3) begin
          data_length_next = {s_tdata, data_length[ByteW-1:0]};
        end
        header_count_next = header_count + 3'd1;
        cks = (header_count == 3'd3 && data_length_next == '0) || s_tlast;
      end else begin
        data_count_next = data_count + 1'b1;
        cks = (data_count_next == data_length) || s_tlast;
        if (pos == 2'd3) begin
          emit             = 1'b1;
          push_entry.op    = OP_GROUP;
          running_sum_next = running_sum + group_sum;
        end else begin
          emit = cks;
        end
        push_entry.cksum = running_sum_next;
      end
      push_entry.with_cksum = cks;
      if (cks) begin
        checksum_done_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count  <= '0;
      data_length   <= '0;
      data_count    <= '0;
      running_sum   <= '0;
      checksum_done <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        header_count  <= '0;
        data_length   <= '0;
        data_count    <= '0;
        running_sum   <= '0;
        checksum_done <= 1'b0;
      end else begin
        header_count  <= header_count_next;
        data_length   <= data_length_next;
        data_count    <= data_count_next;
        running_sum   <= running_sum_next;
        checksum_done <= checksum_done_next;
      end
    end
  end

  // Group buffer: payload only
  always_ff @(posedge clk) begin
    if (accept && !checksum_done && header_count >= 3'(HeaderLen) && pos != 2'd3) begin
      group_buffer[pos] <= x;
    end
  end

endmodule

// ===== rtl/fdesc_queue.sv =====
// ----------------------------------------------------------------------------
// fdesc_queue
// Small register FIFO of work items between front and back end.
// ----------------------------------------------------------------------------
module fdesc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  fdesc_pkg::queue_entry_t           push_entry,
  input  logic                              pop,
  output fdesc_pkg::queue_entry_t           head,
  output logic                              head_valid,
  output logic                              full,
  output logic [$clog2(DEPTH+1)-1:0]        level
);
  import fdesc_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH+1);

  queue_entry_t    entries [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == CntW'(DEPTH));
  assign level      = count;
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    bump = (p == PtrW'(DEPTH-1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== rtl/fdesc_back.sv =====
// ----------------------------------------------------------------------------
// fdesc_back
// Expands work items into result bytes through an output register.
// ----------------------------------------------------------------------------
module fdesc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  fdesc_pkg::queue_entry_t       head,
  input  logic                          head_valid,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [fdesc_pkg::ByteW-1:0]   m_tdata,   // [7:0] out_byte
  output logic [1:0]                    m_tuser,   // [1:0] byte_kind
  output logic                          m_tlast    // run_end
);
  import fdesc_pkg::*;

  logic [StepW-1:0] step, step_next;
  logic [StepW-1:0] n_data;
  logic [StepW-1:0] total;
  logic             is_data;
  logic             last;
  logic             load;
  logic [ByteW-1:0] sel_byte;
  kind_t            sel_kind;

  always_comb begin
    case (head.op)
      OP_HEADER: n_data = 3'd1;
      OP_GROUP:  n_data = 3'(GroupLen);
      default:   n_data = 3'd0;
    endcase
    total    = n_data + {{(StepW-1){1'b0}}, head.with_cksum};
    is_data  = step < n_data;
    last     = (step == total - 3'd1);
    load     = head_valid && (!m_tvalid || m_tready);
    pop      = load && last;
    step_next = load ? (last ? '0 : step + 3'd1) : step;
    if (is_data) begin
      sel_byte = head.bytes[step[1:0]];
      sel_kind = (head.op == OP_HEADER) ? KIND_HEADER : KIND_DATA;
    end else begin
      sel_byte = head.cksum;
      sel_kind = KIND_CKSUM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      step <= step_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= sel_byte;
      m_tuser <= sel_kind;
      m_tlast <= last;
    end
  end

endmodule

// ===== rtl/frame_descrambler_core.sv =====
// ----------------------------------------------------------------------------
// frame_descrambler_core
// Frame descrambler: header pass-through, bit-swap and 1,3,0,2 reorder of data.
// ----------------------------------------------------------------------------
// Results pass the work queue, then the output register. Throughput: one input
//   byte per cycle while the queue is not full; each queued work item drains at
//   one byte per cycle unless stalled (up to five for a full group plus checksum).
// The work queue (QUEUE_DEPTH entries) absorbs output bursts; s_tready drops
//   only while it is full.
// Reset (rst, synchronous, active high) clears frame position, sums, queue
//   and output valid; a byte with s_tlast also returns the frame state to reset.
module frame_descrambler_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [fdesc_pkg::ByteW-1:0]   s_tdata,   // [7:0] rx_byte
  input  logic                          s_tlast,   // frame_end
  // Output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [fdesc_pkg::ByteW-1:0]   m_tdata,   // [7:0] out_byte
  output logic [1:0]                    m_tuser,   // [1:0] byte_kind
  output logic                          m_tlast    // run_end
);
  import fdesc_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH+1);

  // Front to queue
  logic          push;
  queue_entry_t  push_entry;
  logic          q_full;

  // Queue to back
  queue_entry_t  head;
  logic          head_valid;
  logic          pop;
  logic [CntW-1:0] q_level;

  // Front end: header/data tracking, group assembly, checksum accumulation.
  // Every byte that yields results becomes one work item.
  fdesc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Work queue decoupling the two sides
  fdesc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full),
    .level      (q_level)
  );

  // Back end: one result transaction per cycle from the head item when not stalled
  fdesc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

`ifndef SYNTHESIS
  // Queue occupancy never exceeds its depth
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= CntW'(QUEUE_DEPTH))
    else $error("queue level over depth");

  // A checksum is always the final result of its byte
  a_cksum_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_CKSUM |-> m_tlast)
    else $error("checksum without run end");

  // Front stalls only because the queue is full
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_level == CntW'(QUEUE_DEPTH))
    else $error("stall with queue space");

  // Nothing is presented right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule
